[design/lmaf_pkg.sv]
// Package for the MAC address filter bank: opcodes, field widths, table geometry
// and the control struct that the top level passes to each match unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lmaf_pkg;

   localparam int OPCODE_W        = 3;
   localparam int WORD_W          = 32;
   localparam int MAC_W           = 48;
   localparam int HITS_W          = 4;
   localparam int NIBBLE_W        = 4;
   localparam int TABLE_W         = 16;
   localparam int TABLES_PER_UNIT = 12;
   localparam int PAIR_LSB        = 8;
   localparam int LAST_FLAG_BIT   = 9;

   localparam logic [OPCODE_W-1:0] OP_WRITE_SELECT  = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_WRITE_CONTROL = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_LOAD_WORD     = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_READ_CONTROL  = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_READ_REVISION = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_MATCH_ADDRESS = 3'd5;

   typedef struct packed {
      logic load;
      logic last_flag;
   } lmaf_unit_ctrl_type;

endpackage

`default_nettype wire

[design/lmaf_unit.sv]
// One address match unit: twelve 16-entry nibble truth tables, its enable bit,
// the two-bit shift load and the AND of the table verdicts. Uses lmaf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lmaf_unit
   import lmaf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lmaf_unit_ctrl_type ctrl,
   input  wire logic [WORD_W-1:0]  load_word,
   input  wire logic [MAC_W-1:0]   dest_mac,
   output logic                    hit
);

   logic [TABLE_W-1:0] tbl_ff [TABLES_PER_UNIT];
   logic [TABLE_W-1:0] tbl_in [TABLES_PER_UNIT];
   logic               enable_ff;
   logic               enable_in;
   logic [TABLES_PER_UNIT-1:0] verdict;

   for (genvar t = 0; t < TABLES_PER_UNIT; t++) begin : g_table
      always_comb begin
         tbl_in[t] = tbl_ff[t];
         if (ctrl.load) begin
            tbl_in[t] = {tbl_ff[t][TABLE_W-3:0], load_word[PAIR_LSB + 2*t +: 2]};
         end
      end

      assign verdict[t] = tbl_ff[t][dest_mac[NIBBLE_W*t +: NIBBLE_W]];

      always_ff @(posedge clock) begin
         if (reset) begin
            tbl_ff[t] <= '0;
         end else begin
            tbl_ff[t] <= tbl_in[t];
         end
      end
   end

   always_comb begin
      enable_in = enable_ff;
      if (ctrl.load) begin
         enable_in = ctrl.last_flag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else begin
         enable_ff <= enable_in;
      end
   end

   assign hit = enable_ff & (&verdict);

endmodule

`default_nettype wire

[design/lut_mac_address_filter_bank.sv]
// Top level of the MAC address filter bank: input register, opcode decode,
// the bank of lmaf_unit match units and the result register. Uses lmaf_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The bank takes one item per clock cycle while the output is not stalled and
// returns exactly one result item for each. An item is captured in the input
// register, decoded and looked up against all unit tables combinationally, and
// its result lands in the result register that drives the output ports. Loads,
// select and control writes take effect in order, so a match query sees every
// write accepted before it. The result register and the input register each
// hold one item, which lets a new item enter while a finished result waits. A
// revision read reports NUM_UNITS in bits 15:8.
module lut_mac_address_filter_bank
   import lmaf_pkg::*;
#(
   parameter int NUM_UNITS = 4
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [OPCODE_W-1:0]  req_opcode,
   input  wire logic [WORD_W-1:0]    req_write_data,
   input  wire logic [MAC_W-1:0]     req_dest_mac,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [WORD_W-1:0]         rsp_read_data,
   output logic [HITS_W-1:0]         rsp_unit_hits,
   output logic                      rsp_accepted
);

   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic [OPCODE_W-1:0]   in_opcode_ff;
   logic [WORD_W-1:0]     in_write_data_ff;
   logic [MAC_W-1:0]      in_dest_mac_ff;

   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic [WORD_W-1:0]     out_read_data_ff;
   logic [WORD_W-1:0]     out_read_data_in;
   logic [HITS_W-1:0]     out_unit_hits_ff;
   logic [HITS_W-1:0]     out_unit_hits_in;
   logic                  out_accepted_ff;
   logic                  out_accepted_in;

   logic [NUM_UNITS-1:0]  select_ff;
   logic [NUM_UNITS-1:0]  select_in;
   logic                  last_flag_ff;
   logic                  last_flag_in;

   logic                  advance;
   logic                  fire;
   logic                  req_take;
   logic                  is_load;
   logic [NUM_UNITS-1:0]  hits;
   logic [NUM_UNITS+HITS_W-1:0] hits_ext;

   assign advance  = !out_valid_ff || !rsp_stall;
   assign fire     = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_take = req_valid && !req_stall;
   assign is_load  = fire && (in_opcode_ff == OP_LOAD_WORD);

   for (genvar u = 0; u < NUM_UNITS; u++) begin : g_unit
      lmaf_unit_ctrl_type ctrl;

      assign ctrl.load      = is_load && select_ff[u];
      assign ctrl.last_flag = last_flag_ff;

      lmaf_unit u_unit (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .load_word (in_write_data_ff),
         .dest_mac  (in_dest_mac_ff),
         .hit       (hits[u])
      );
   end

   assign hits_ext = {{HITS_W{1'b0}}, hits};

   always_comb begin
      select_in        = select_ff;
      last_flag_in     = last_flag_ff;
      out_read_data_in = '0;
      out_unit_hits_in = '0;
      out_accepted_in  = 1'b0;
      unique case (in_opcode_ff)
         OP_WRITE_SELECT: begin
            if (fire) begin
               select_in = in_write_data_ff[NUM_UNITS-1:0];
            end
         end
         OP_WRITE_CONTROL: begin
            if (fire) begin
               last_flag_in = in_write_data_ff[LAST_FLAG_BIT];
            end
         end
         OP_LOAD_WORD: begin
         end
         OP_READ_CONTROL: begin
            out_read_data_in[LAST_FLAG_BIT] = last_flag_ff;
         end
         OP_READ_REVISION: begin
            out_read_data_in = {16'd0, 8'(NUM_UNITS), 8'd0};
         end
         OP_MATCH_ADDRESS: begin
            out_unit_hits_in = hits_ext[HITS_W-1:0];
            out_accepted_in  = |hits;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         select_ff    <= '0;
         last_flag_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         select_ff    <= select_in;
         last_flag_ff <= last_flag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_opcode_ff     <= req_opcode;
         in_write_data_ff <= req_write_data;
         in_dest_mac_ff   <= req_dest_mac;
      end
      if (fire) begin
         out_read_data_ff <= out_read_data_in;
         out_unit_hits_ff <= out_unit_hits_in;
         out_accepted_ff  <= out_accepted_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_read_data = out_read_data_ff;
   assign rsp_unit_hits = out_unit_hits_ff;
   assign rsp_accepted  = out_accepted_ff;

endmodule

`default_nettype wire

[design/lmaf_checker.sv]
// Port-level checker for the MAC address filter bank and the bind that
// attaches it to the top level. Uses lmaf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lmaf_checker
   import lmaf_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_stall,
   input  wire logic [OPCODE_W-1:0]  req_opcode,
   input  wire logic [WORD_W-1:0]    req_write_data,
   input  wire logic [MAC_W-1:0]     req_dest_mac,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire logic [WORD_W-1:0]    rsp_read_data,
   input  wire logic [HITS_W-1:0]    rsp_unit_hits,
   input  wire logic                 rsp_accepted
);

   // A unit hit shown among the low units must also raise the overall verdict.
   a_hits_imply_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_unit_hits != '0) |-> rsp_accepted)
      else $error("unit hit without accepted");

   // Match results and read data never appear in the same item.
   a_match_no_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> (rsp_read_data == '0))
      else $error("read data on a match item");

   // Reads only ever drive the last flag or the revision byte.
   a_read_bits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_read_data & ~32'h0000_FF00) == '0))
      else $error("read data outside defined bits");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_data)
         && $stable(rsp_unit_hits) && $stable(rsp_accepted))
      else $error("stalled result changed");

   // A stalled input item stays offered and unchanged.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_opcode)
         && $stable(req_write_data) && $stable(req_dest_mac))
      else $error("stalled input item changed");

endmodule

bind lut_mac_address_filter_bank lmaf_checker u_lmaf_checker (.*);

`default_nettype wire

[tb/lut_mac_address_filter_bank_tb.sv]
// Self-checking testbench for lut_mac_address_filter_bank: directed register, load and match
// items, random load sequences, queries and random opcodes under random idling and a long output hold-off.
// Depends on lmaf_pkg and the lut_mac_address_filter_bank RTL.
`timescale 1ns / 1ps

module lut_mac_address_filter_bank_tb;
   import lmaf_pkg::*;

   localparam int NUM_UNITS = 4;
   localparam int WORDS_PER_LOAD = 8;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int DRAIN_CYCLES = 10;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [OPCODE_W-1:0] OP_UNUSED_LOW = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_UNUSED_HIGH = 3'd7;
   localparam logic [WORD_W-1:0] CTRL_LAST = 32'h1 << LAST_FLAG_BIT;
   localparam logic [WORD_W-1:0] ALL_ONES = '1;

   typedef struct packed {
      logic [WORD_W-1:0] read_data;
      logic [HITS_W-1:0] unit_hits;
      logic              accepted;
   } filter_resp_t;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [OPCODE_W-1:0] req_opcode;
   logic [WORD_W-1:0]   req_write_data;
   logic [MAC_W-1:0]    req_dest_mac;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [WORD_W-1:0]   rsp_read_data;
   logic [HITS_W-1:0]   rsp_unit_hits;
   logic                rsp_accepted;

   logic [TABLE_W-1:0]   nibble_tables [NUM_UNITS][TABLES_PER_UNIT];
   logic [NUM_UNITS-1:0] unit_enable;
   logic [NUM_UNITS-1:0] unit_select;
   logic                 last_word_flag;

   filter_resp_t owed_responses[$];
   int   error_count = 0;
   int   cycle_count = 0;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   logic rsp_hold = 1'b0;
   event hold_off_start;

   lut_mac_address_filter_bank #(
      .NUM_UNITS(NUM_UNITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_write_data(req_write_data),
      .req_dest_mac(req_dest_mac),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_read_data(rsp_read_data),
      .rsp_unit_hits(rsp_unit_hits),
      .rsp_accepted(rsp_accepted)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= rsp_hold || ($urandom_range(99) < recv_stall_pct);
   end

   always begin
      @(hold_off_start);
      rsp_hold <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   function automatic filter_resp_t apply_filter_op(input logic [OPCODE_W-1:0] op,
                                                   input logic [WORD_W-1:0] wd,
                                                   input logic [MAC_W-1:0] mac);
      filter_resp_t         resp;
      logic [NUM_UNITS-1:0] hits;
      logic                 unit_ok;
      resp = '0;
      hits = '0;
      case (op)
         OP_WRITE_SELECT: begin
            unit_select = wd[NUM_UNITS-1:0];
         end
         OP_WRITE_CONTROL: begin
            last_word_flag = wd[LAST_FLAG_BIT];
         end
         OP_LOAD_WORD: begin
            for (int u = 0; u < NUM_UNITS; u++) begin
               if (unit_select[u]) begin
                  for (int t = 0; t < TABLES_PER_UNIT; t++) begin
                     nibble_tables[u][t] = {nibble_tables[u][t][TABLE_W-3:0],
                                            wd[PAIR_LSB+2*t +: 2]};
                  end
                  unit_enable[u] = last_word_flag;
               end
            end
         end
         OP_READ_CONTROL: begin
            resp.read_data[LAST_FLAG_BIT] = last_word_flag;
         end
         OP_READ_REVISION: begin
            resp.read_data[15:8] = 8'(NUM_UNITS);
         end
         OP_MATCH_ADDRESS: begin
            for (int u = 0; u < NUM_UNITS; u++) begin
               unit_ok = unit_enable[u];
               for (int t = 0; t < TABLES_PER_UNIT; t++) begin
                  unit_ok = unit_ok && nibble_tables[u][t][mac[NIBBLE_W*t +: NIBBLE_W]];
               end
               hits[u] = unit_ok;
            end
            resp.unit_hits = HITS_W'(hits);
            resp.accepted = |hits;
         end
         default: begin
         end
      endcase
      return resp;
   endfunction

   task automatic report_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : check_responses
      filter_resp_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_responses.size() == 0) begin
            $display("%0t ns: unexpected item, expected none, got %h %h %b", $time,
                     rsp_read_data, rsp_unit_hits, rsp_accepted);
            error_count++;
         end else begin
            want = owed_responses.pop_front();
            report_field("read_data", want.read_data, rsp_read_data);
            report_field("unit_hits", WORD_W'(want.unit_hits), WORD_W'(rsp_unit_hits));
            report_field("accepted", WORD_W'(want.accepted), WORD_W'(rsp_accepted));
         end
      end
   end

   task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [WORD_W-1:0] wd,
                            input logic [MAC_W-1:0] mac);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_write_data <= wd;
      req_dest_mac <= mac;
      do @(posedge clock); while (req_stall);
      owed_responses.push_back(apply_filter_op(op, wd, mac));
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (owed_responses.size() != 0) @(posedge clock);
   endtask

   function automatic logic [MAC_W-1:0] random_mac();
      return MAC_W'({$urandom, $urandom});
   endfunction

   task automatic test_register_reads();
      send_item(OP_READ_REVISION, '0, '0);
      send_item(OP_READ_CONTROL, '0, '0);
      send_item(OP_WRITE_CONTROL, CTRL_LAST, '0);
      send_item(OP_READ_CONTROL, ALL_ONES, '1);
      send_item(OP_WRITE_CONTROL, ~CTRL_LAST, '0);
      send_item(OP_READ_CONTROL, '0, '0);
      send_item(OP_WRITE_CONTROL, ALL_ONES, '1);
      send_item(OP_READ_CONTROL, '0, '0);
      send_item(OP_UNUSED_LOW, ALL_ONES, '1);
      send_item(OP_UNUSED_HIGH, ALL_ONES, '1);
      send_item(OP_MATCH_ADDRESS, '0, '0);
      send_item(OP_MATCH_ADDRESS, ALL_ONES, '1);
   endtask

   task automatic test_table_load();
      send_item(OP_WRITE_SELECT, ALL_ONES, '0);
      send_item(OP_WRITE_CONTROL, '0, '0);
      send_item(OP_LOAD_WORD, ALL_ONES, '0);
      send_item(OP_LOAD_WORD, ALL_ONES, '0);
      send_item(OP_MATCH_ADDRESS, '0, '0);
      send_item(OP_WRITE_CONTROL, CTRL_LAST, '0);
      send_item(OP_LOAD_WORD, ALL_ONES, '0);
      send_item(OP_MATCH_ADDRESS, '0, '0);
      send_item(OP_MATCH_ADDRESS, '0, '1);
      send_item(OP_WRITE_SELECT, ~WORD_W'(2 ** NUM_UNITS - 1), '0);
      send_item(OP_LOAD_WORD, '0, '0);
   endtask

   task automatic test_random_traffic(input int item_count);
      int                  sent;
      int                  pick;
      int                  unit;
      int                  nib;
      logic [WORD_W-1:0]   wd;
      logic [MAC_W-1:0]    mac;
      logic [OPCODE_W-1:0] op;
      sent = 0;
      while (sent < item_count) begin
         pick = $urandom_range(9);
         if (pick < 6) begin
            wd = ($urandom_range(7) == 0) ? WORD_W'(0) : WORD_W'($urandom);
            send_item(OP_WRITE_SELECT, wd, random_mac());
            wd = $urandom;
            wd[LAST_FLAG_BIT] = 1'b0;
            send_item(OP_WRITE_CONTROL, wd, random_mac());
            for (int w = 0; w < WORDS_PER_LOAD - 1; w++) begin
               send_item(OP_LOAD_WORD, $urandom | $urandom, random_mac());
            end
            wd = $urandom;
            wd[LAST_FLAG_BIT] = 1'b1;
            send_item(OP_WRITE_CONTROL, wd, random_mac());
            send_item(OP_LOAD_WORD, $urandom | $urandom, random_mac());
            sent += WORDS_PER_LOAD + 3;
         end
         if (pick < 8) begin
            repeat ($urandom_range(2, 6)) begin
               mac = random_mac();
               if ($urandom_range(1) == 1) begin
                  unit = $urandom_range(NUM_UNITS - 1);
                  for (int t = 0; t < TABLES_PER_UNIT; t++) begin
                     if (nibble_tables[unit][t] != '0) begin
                        do nib = $urandom_range(15); while (!nibble_tables[unit][t][nib]);
                        mac[NIBBLE_W*t +: NIBBLE_W] = NIBBLE_W'(nib);
                     end
                  end
               end
               send_item(OP_MATCH_ADDRESS, $urandom, mac);
               sent++;
            end
         end else begin
            repeat ($urandom_range(1, 8)) begin
               op = OPCODE_W'($urandom_range(7));
               send_item(op, $urandom, random_mac());
               sent++;
            end
         end
      end
   endtask

   task automatic test_output_hold_off();
      -> hold_off_start;
      for (int i = 0; i < 24; i++) begin
         if (i % 3 == 0) begin
            send_item(OP_READ_CONTROL, $urandom, random_mac());
         end else begin
            send_item(OP_MATCH_ADDRESS, $urandom, random_mac());
         end
      end
      pause_until_drained();
   endtask

   initial begin
      for (int u = 0; u < NUM_UNITS; u++) begin
         for (int t = 0; t < TABLES_PER_UNIT; t++) begin
            nibble_tables[u][t] = '0;
         end
      end
      unit_enable = '0;
      unit_select = '0;
      last_word_flag = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_opcode <= OP_READ_CONTROL;
      req_write_data <= '0;
      req_dest_mac <= '0;
      rsp_stall <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 21;
      recv_stall_pct = 54;
      test_register_reads();
      test_table_load();
      test_random_traffic(170);
      pause_until_drained();

      send_idle_pct = 54;
      recv_stall_pct = 21;
      test_random_traffic(170);

      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_random_traffic(170);
      test_output_hold_off();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
